// ----- rtl/uvsm_pkg.sv -----
package uvsm_pkg;

   // Widths of the request and result fields.
   localparam int SLICE_W    = 9;
   localparam int ROW_W      = 8;
   localparam int INDEX_W    = 16;
   localparam int RADIUS_W   = 16;
   localparam int POS_W      = 17;
   localparam int NORM_W     = 16;
   localparam int TEX_W      = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 152;

   // Slice count limits and register defaults.
   localparam logic [SLICE_W-1:0]  MIN_SLICES     = 9'd4;
   localparam logic [SLICE_W-1:0]  MAX_SLICES     = 9'd256;
   localparam logic [SLICE_W-1:0]  SLICES_DEFAULT = 9'd16;
   localparam logic [RADIUS_W-1:0] RADIUS_DEFAULT = 16'd256;

   // Reciprocals that belong to the default slice count of 16.
   localparam logic [31:0] RECIP_S_DEFAULT = 32'h2000_0000;
   localparam logic [30:0] QUOT_S_DEFAULT  = 31'h1000_0000;
   localparam logic [8:0]  REM_S_DEFAULT   = 9'd0;
   localparam logic [30:0] RECIP_P_DEFAULT = 31'h1000_0000;

   // Exponents of the two reciprocals, 2^33/S and 2^31/P.
   localparam int EXP_S = 33;
   localparam int EXP_P = 31;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;
   localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;

   localparam logic signed [32:0] ATAN_TURNS [CORDIC_STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81,
      33'sd41,        33'sd20,        33'sd10,        33'sd5,
      33'sd3,         33'sd1
   };

   typedef enum logic {
      OP_VERTEX = 1'b0,
      OP_QUAD   = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_SLICE_COUNT = 1'b0,
      REG_RADIUS      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
   } cvec_type;

   typedef struct packed {
      logic signed [31:0] sn;
      logic signed [31:0] cs;
   } sincos_type;

   // Item data that rides along the datapath.
   typedef struct packed {
      opcode_type         op;
      logic               oor;
      logic [INDEX_W-1:0] idx;
      logic [INDEX_W-1:0] bidx;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
      logic [1:0]         qa;
      logic [1:0]         qb;
   } side_type;

   function automatic cvec_type cordic_step(cvec_type v, int unsigned k);
      cvec_type           r;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      dx = v.y >>> k;
      dy = v.x >>> k;
      if (!v.z[32]) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - ATAN_TURNS[k];
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + ATAN_TURNS[k];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_q30(logic signed [32:0] v);
      logic signed [32:0] t;
      if (v > Q30_ONE) begin
         t = Q30_ONE;
      end else if (v < -Q30_ONE) begin
         t = -Q30_ONE;
      end else begin
         t = v;
      end
      return t[31:0];
   endfunction

   // Quadrant unfolding of a first-quadrant rotation result.
   function automatic sincos_type quad_map(cvec_type v, logic [1:0] q);
      sincos_type         r;
      logic signed [31:0] xc;
      logic signed [31:0] yc;
      xc = sat_q30(v.x);
      yc = sat_q30(v.y);
      case (q)
         2'd0: begin
            r.cs = xc;
            r.sn = yc;
         end
         2'd1: begin
            r.cs = -yc;
            r.sn = xc;
         end
         2'd2: begin
            r.cs = -xc;
            r.sn = -yc;
         end
         default: begin
            r.cs = yc;
            r.sn = -xc;
         end
      endcase
      return r;
   endfunction

   // Round a Q2.60 product back to Q1.30, half up, and saturate.
   function automatic logic signed [31:0] round_prod(logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd536870912) >>> 30;
      if (t > 64'sd1073741824) begin
         t = 64'sd1073741824;
      end else if (t < -64'sd1073741824) begin
         t = -64'sd1073741824;
      end
      return t[31:0];
   endfunction

   function automatic logic signed [POS_W-1:0] round_pos(logic signed [48:0] p);
      logic signed [48:0] t;
      t = (p + 49'sd536870912) >>> 30;
      if (t > 49'sd65535) begin
         t = 49'sd65535;
      end else if (t < -49'sd65535) begin
         t = -49'sd65535;
      end
      return t[POS_W-1:0];
   endfunction

   function automatic logic signed [NORM_W-1:0] round_norm(logic signed [31:0] q);
      logic signed [31:0] t;
      t = (q + 32'sd32768) >>> 16;
      if (t > 32'sd16384) begin
         t = 32'sd16384;
      end else if (t < -32'sd16384) begin
         t = -32'sd16384;
      end
      return t[NORM_W-1:0];
   endfunction

endpackage

// ----- rtl/uvsm_recip.sv -----
module uvsm_recip #(
   parameter int EXP = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [uvsm_pkg::SLICE_W-1:0] divisor,
   output logic                         busy,
   output logic                         done,
   output logic [EXP-1:0]               quot,
   output logic [uvsm_pkg::SLICE_W-1:0] rem
);
   import uvsm_pkg::*;

   localparam int CW = $clog2(EXP + 1);

   logic [CW-1:0]      cnt_ff;
   logic               done_ff;
   logic [SLICE_W-1:0] rem_ff;
   logic [EXP-1:0]     quot_ff;
   logic [SLICE_W:0]   trial;
   logic               fits;

   // Restoring division of 2^EXP by the divisor, one quotient bit a cycle.
   // The leading one of the dividend is preloaded into the remainder.
   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CW'(EXP);
         done_ff <= 1'b0;
      end else begin
         done_ff <= cnt_ff == CW'(1);
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= SLICE_W'(1);
         quot_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= fits ? SLICE_W'(trial - {1'b0, divisor}) : trial[SLICE_W-1:0];
         quot_ff <= {quot_ff[EXP-2:0], fits};
      end
   end

   assign busy = cnt_ff != '0;
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/uv_sphere_mesh_generator_top.sv -----
// UV sphere tessellator. A vertex request (tuser 0) for row i and column j returns one
// transfer with the vertex number i*(S+1)+j, the position, the unit normal and the texture
// coordinates; a quad request (tuser 1) returns six transfers carrying the triangle indices
// A, B, B+1, A, B+1, A+1, the last one marked with tlast. Requests outside the grid return
// a single transfer with tuser set. The datapath is a 39-stage pipeline (three stages of
// phase arithmetic, thirty CORDIC stages, five stages of products and rounding, the output
// register) and takes one request every cycle while neither the output nor a reciprocal
// update holds it; a quad request occupies the output register for six transfers and holds
// the datapath until the last one is taken. Writing slice_count starts two bit-serial
// reciprocal dividers; req_tready stays low after the write while they run. Writing
// radius_q8 takes effect at once.
module uv_sphere_mesh_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata fields from bit 0 up: row [7:0], column [16:8], zero padding.
   input  logic [uvsm_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser fields: opcode [0].
   input  logic                            req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata fields from bit 0 up: vertex_index [15:0], pos_x [32:16], pos_y [49:33],
   // pos_z [66:50], norm_x [82:67], norm_y [98:83], norm_z [114:99], tex_u [130:115],
   // tex_v [146:131], zero padding.
   output logic [uvsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // rsp_tuser fields: out_of_range [0].
   output logic                            rsp_tuser,
   // Configuration writes.
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [uvsm_pkg::RADIUS_W-1:0]   csr_wdata
);
   import uvsm_pkg::*;

   // Pipeline stage numbers. The first CORDIC stage follows the phase stages.
   localparam int CS0       = 4;
   localparam int ST_MAP    = CS0 + CORDIC_STEPS;
   localparam int ST_PROD   = ST_MAP + 1;
   localparam int ST_ROUND  = ST_PROD + 1;
   localparam int ST_RADIUS = ST_ROUND + 1;
   localparam int NST       = ST_RADIUS + 1;
   localparam logic [2:0] LAST_BEAT = 3'd5;

   // ------------------------------------------------------------------
   // Configuration registers and reciprocal generation.
   // ------------------------------------------------------------------
   logic [SLICE_W-1:0]  s_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic                start_ff;
   logic [31:0]         recip_s_ff;
   logic [30:0]         quot_s_ff;
   logic [8:0]          rem_s_ff;
   logic [30:0]         recip_p_ff;
   logic [SLICE_W-1:0]  s_in;
   logic [ROW_W-1:0]    p;
   logic                busy_a;
   logic                busy_b;
   logic                done_a;
   logic                done_b;
   logic [EXP_S-1:0]    quot_a;
   logic [EXP_P-1:0]    quot_b;
   logic [SLICE_W-1:0]  rem_a;
   logic [SLICE_W-1:0]  rem_b;
   logic [SLICE_W:0]    rem_sum;
   logic                cfg_busy;

   // The slice count is clamped to its legal range when it is written.
   always_comb begin
      if (csr_wdata[SLICE_W-1:0] < MIN_SLICES) begin
         s_in = MIN_SLICES;
      end else if (csr_wdata[SLICE_W-1:0] > MAX_SLICES) begin
         s_in = MAX_SLICES;
      end else begin
         s_in = csr_wdata[SLICE_W-1:0];
      end
   end

   assign p = s_ff[SLICE_W-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff      <= SLICES_DEFAULT;
         radius_ff <= RADIUS_DEFAULT;
         start_ff  <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_SLICE_COUNT: begin
                  s_ff     <= s_in;
                  start_ff <= 1'b1;
               end
               REG_RADIUS: begin
                  radius_ff <= csr_wdata;
               end
            endcase
         end
      end
   end

   // Divider A gives 2^33 = Qa*S + Ra. From it come M = ceil(2^33/S), used to divide the
   // small numerators below, and the pair floor(2^32/S), 2^32 mod S that splits the phase
   // k*2^32/S into a wide product and a narrow remainder term. Divider B gives
   // ceil(2^31/P) for the v texture coordinate.
   uvsm_recip #(
      .EXP (EXP_S)
   ) u_recip_s (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .divisor (s_ff),
      .busy    (busy_a),
      .done    (done_a),
      .quot    (quot_a),
      .rem     (rem_a)
   );

   uvsm_recip #(
      .EXP (EXP_P)
   ) u_recip_p (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .divisor ({1'b0, p}),
      .busy    (busy_b),
      .done    (done_b),
      .quot    (quot_b),
      .rem     (rem_b)
   );

   assign rem_sum = (quot_a[0] ? {1'b0, s_ff} : '0) + {1'b0, rem_a};

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_s_ff <= RECIP_S_DEFAULT;
         quot_s_ff  <= QUOT_S_DEFAULT;
         rem_s_ff   <= REM_S_DEFAULT;
         recip_p_ff <= RECIP_P_DEFAULT;
      end else begin
         if (done_a) begin
            recip_s_ff <= quot_a[31:0] + {31'd0, |rem_a};
            quot_s_ff  <= quot_a[31:1];
            rem_s_ff   <= rem_sum[SLICE_W:1];
         end
         if (done_b) begin
            recip_p_ff <= quot_b[30:0] + {30'd0, |rem_b};
         end
      end
   end

   assign cfg_busy = start_ff | busy_a | busy_b | done_a | done_b;

   // ------------------------------------------------------------------
   // Input skid register and pipeline advance.
   // ------------------------------------------------------------------
   logic                en;
   logic                req_accept;
   logic                skid_valid_ff;
   opcode_type          skid_op_ff;
   logic [ROW_W-1:0]    skid_row_ff;
   logic [SLICE_W-1:0]  skid_col_ff;
   logic                e_valid;
   opcode_type          e_op;
   logic [ROW_W-1:0]    e_row;
   logic [SLICE_W-1:0]  e_col;

   // The whole datapath moves together when the output register can take an item. The
   // skid register catches one request while the datapath holds.
   assign req_tready = !skid_valid_ff && !cfg_busy;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && !en) begin
         skid_op_ff  <= opcode_type'(req_tuser);
         skid_row_ff <= req_tdata[ROW_W-1:0];
         skid_col_ff <= req_tdata[ROW_W+SLICE_W-1:ROW_W];
      end
   end

   assign e_valid = skid_valid_ff || req_accept;
   assign e_op    = skid_valid_ff ? skid_op_ff : opcode_type'(req_tuser);
   assign e_row   = skid_valid_ff ? skid_row_ff : req_tdata[ROW_W-1:0];
   assign e_col   = skid_valid_ff ? skid_col_ff : req_tdata[ROW_W+SLICE_W-1:ROW_W];

   // ------------------------------------------------------------------
   // Stage 1: range checks, vertex number and numerators.
   // ------------------------------------------------------------------
   logic      [NST:1] vld_ff;
   side_type          side_ff [1:NST];
   side_type          side1;
   side_type          side2_in;
   side_type          side_cs_in;
   logic [38:0]       kq_i;
   logic [39:0]       kq_j;
   logic [31:0]       kq_i1_ff;
   logic [31:0]       kq_j1_ff;
   logic [16:0]       xi1_ff;
   logic [16:0]       xj1_ff;
   logic [23:0]       xu1_ff;
   logic [22:0]       xv1_ff;

   always_comb begin
      side1       = '0;
      side1.op    = e_op;
      side1.oor   = (e_op == OP_QUAD) ? (e_row >= p || e_col >= s_ff)
                                      : (e_row > p || e_col > s_ff);
      side1.idx   = 16'(e_row) * (16'(s_ff) + 16'd1) + 16'(e_col);
   end

   assign kq_i = 39'(e_row) * 39'(quot_s_ff);
   assign kq_j = 40'(e_col) * 40'(quot_s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         kq_i1_ff <= kq_i[31:0];
         kq_j1_ff <= kq_j[31:0];
         xi1_ff   <= 17'(e_row) * 17'(rem_s_ff) + 17'(p);
         xj1_ff   <= 17'(e_col) * 17'(rem_s_ff) + 17'(p);
         xu1_ff   <= {e_col, 15'd0} + 24'(p);
         xv1_ff   <= {8'(p - e_row), 15'd0} + 23'(p[ROW_W-1:1]);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: reciprocal products. Stage 3: phase words.
   // ------------------------------------------------------------------
   logic [48:0] prod_ci;
   logic [48:0] prod_cj;
   logic [55:0] prod_u;
   logic [53:0] prod_v;
   logic [31:0] kq_i2_ff;
   logic [31:0] kq_j2_ff;
   logic [15:0] ci2_ff;
   logic [15:0] cj2_ff;
   logic [31:0] ph_i3_ff;
   logic [31:0] ph_j3_ff;

   assign prod_ci = 49'(xi1_ff) * 49'(recip_s_ff);
   assign prod_cj = 49'(xj1_ff) * 49'(recip_s_ff);
   assign prod_u  = 56'(xu1_ff) * 56'(recip_s_ff);
   assign prod_v  = 54'(xv1_ff) * 54'(recip_p_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         kq_i2_ff <= kq_i1_ff;
         kq_j2_ff <= kq_j1_ff;
         ci2_ff   <= prod_ci[48:33];
         cj2_ff   <= prod_cj[48:33];
         ph_i3_ff <= kq_i2_ff + 32'(ci2_ff);
         ph_j3_ff <= kq_j2_ff + 32'(cj2_ff);
      end
   end

   // Item data shifts along with the datapath; fields are filled in where they are known.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-1:1], e_valid};
      end
   end

   always_comb begin
      side2_in       = side_ff[1];
      side2_in.bidx  = side_ff[1].idx + 16'(s_ff) + 16'd1;
      side2_in.tex_u = prod_u[48:33];
      side2_in.tex_v = prod_v[46:31];
      side_cs_in     = side_ff[CS0-1];
      side_cs_in.qa  = ph_i3_ff[31:30];
      side_cs_in.qb  = ph_j3_ff[31:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= side1;
         side_ff[2] <= side2_in;
         for (int n = 3; n <= NST; n++) begin
            side_ff[n] <= (n == CS0) ? side_cs_in : side_ff[n-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // CORDIC: one rotation step per stage for both angles.
   // ------------------------------------------------------------------
   cvec_type cva_ff [CORDIC_STEPS];
   cvec_type cvb_ff [CORDIC_STEPS];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      cvec_type a_in;
      cvec_type b_in;
      if (k == 0) begin : g_first
         assign a_in = '{x: CORDIC_GAIN, y: '0, z: {3'b0, ph_i3_ff[29:0]}};
         assign b_in = '{x: CORDIC_GAIN, y: '0, z: {3'b0, ph_j3_ff[29:0]}};
      end else begin : g_rest
         assign a_in = cva_ff[k-1];
         assign b_in = cvb_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cva_ff[k] <= cordic_step(a_in, k);
            cvb_ff[k] <= cordic_step(b_in, k);
         end
      end
   end

   // ------------------------------------------------------------------
   // Quadrant unfolding, sine products, radius scaling and rounding.
   // ------------------------------------------------------------------
   sincos_type                 sca_ff;
   sincos_type                 scb_ff;
   logic signed [63:0]         pab_ff;
   logic signed [63:0]         pac_ff;
   logic signed [31:0]         ca_ff;
   logic signed [31:0]         qv_ff [3];
   logic signed [48:0]         rq_ff [3];
   logic signed [NORM_W-1:0]   nrm_r_ff [3];
   logic signed [POS_W-1:0]    pos_ff [3];
   logic signed [NORM_W-1:0]   nrm_ff [3];
   logic signed [RADIUS_W:0]   radius_s;

   assign radius_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         sca_ff   <= quad_map(cva_ff[CORDIC_STEPS-1], side_ff[ST_MAP-1].qa);
         scb_ff   <= quad_map(cvb_ff[CORDIC_STEPS-1], side_ff[ST_MAP-1].qb);
         pab_ff   <= 64'(sca_ff.sn) * 64'(scb_ff.sn);
         pac_ff   <= 64'(sca_ff.sn) * 64'(scb_ff.cs);
         ca_ff    <= sca_ff.cs;
         qv_ff[0] <= round_prod(pab_ff);
         qv_ff[1] <= ca_ff;
         qv_ff[2] <= round_prod(pac_ff);
         for (int c = 0; c < 3; c++) begin
            rq_ff[c]    <= 49'(radius_s) * 49'(qv_ff[c]);
            nrm_r_ff[c] <= round_norm(qv_ff[c]);
            pos_ff[c]   <= round_pos(rq_ff[c]);
            nrm_ff[c]   <= nrm_r_ff[c];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register. A quad request stays here for six transfers.
   // ------------------------------------------------------------------
   logic                     out_valid_ff;
   logic [2:0]               beat_ff;
   side_type                 out_side_ff;
   logic signed [POS_W-1:0]  out_pos_ff [3];
   logic signed [NORM_W-1:0] out_nrm_ff [3];
   logic                     out_quad;
   logic                     out_last;
   logic [INDEX_W-1:0]       tri_index;
   logic [INDEX_W-1:0]       rsp_index;
   logic                     show_vertex;

   assign out_quad = out_side_ff.op == OP_QUAD && !out_side_ff.oor;
   assign out_last = !out_quad || beat_ff == LAST_BEAT;
   assign en       = !out_valid_ff || (rsp_tready && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else if (en) begin
         out_valid_ff <= vld_ff[NST];
         beat_ff      <= '0;
      end else if (rsp_tready) begin
         beat_ff <= beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side_ff <= side_ff[NST];
         out_pos_ff  <= pos_ff;
         out_nrm_ff  <= nrm_ff;
      end
   end

   // Triangle order of a quad: A, B, B+1 and A, B+1, A+1.
   always_comb begin
      case (beat_ff)
         3'd0:    tri_index = out_side_ff.idx;
         3'd1:    tri_index = out_side_ff.bidx;
         3'd2:    tri_index = out_side_ff.bidx + 16'd1;
         3'd3:    tri_index = out_side_ff.idx;
         3'd4:    tri_index = out_side_ff.bidx + 16'd1;
         default: tri_index = out_side_ff.idx + 16'd1;
      endcase
   end

   // Only an in-range vertex shows geometry; flagged and quad results carry zeros there.
   assign show_vertex = out_side_ff.op == OP_VERTEX && !out_side_ff.oor;
   assign rsp_index   = out_quad ? tri_index : (show_vertex ? out_side_ff.idx : '0);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tuser  = out_side_ff.oor;
   assign rsp_tdata  = show_vertex
      ? {5'd0, out_side_ff.tex_v, out_side_ff.tex_u,
         out_nrm_ff[2], out_nrm_ff[1], out_nrm_ff[0],
         out_pos_ff[2], out_pos_ff[1], out_pos_ff[0], rsp_index}
      : {136'd0, rsp_index};

endmodule
